// File: design/fbpa_pkg.sv
package fbpa_pkg;

   // Sizing of the allocator. MAX_POOL_SLOTS must be a power of two, since a
   // handle is the pool number above the slot number.
   localparam int MAX_POOL_SLOTS = 256;
   localparam int MAX_POOLS      = 16;
   localparam int LINK_BYTES     = 8;

   // Fixed field widths.
   localparam int HANDLE_W  = 12;
   localparam int POOL_W    = 4;
   localparam int OFFSET_W  = 24;
   localparam int OBJ_W     = 16;
   localparam int SPP_W     = 9;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = OBJ_W;

   // Derived widths.
   localparam int SLOT_W     = $clog2(MAX_POOL_SLOTS);
   localparam int USED_W     = $clog2(MAX_POOL_SLOTS + 1);
   localparam int POOL_CNT_W = $clog2(MAX_POOLS + 1);
   localparam int STRIDE_W   = OBJ_W + 1;
   localparam int LINK_W     = HANDLE_W + 1;
   localparam int LINK_DEPTH = 2 ** HANDLE_W;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_OBJECT_SIZE    = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_SLOTS_PER_POOL = 1'b1;

   // Reset values of the configuration registers.
   localparam logic [OBJ_W-1:0] OBJECT_SIZE_RESET    = 16'd16;
   localparam logic [SPP_W-1:0] SLOTS_PER_POOL_RESET = 9'd256;

   // Result status codes.
   localparam logic STATUS_DONE = 1'b0;
   localparam logic STATUS_OOM  = 1'b1;

   typedef enum logic {
      OP_ALLOC   = 1'b0,
      OP_RELEASE = 1'b1
   } op_type;

   typedef struct packed {
      op_type              operation;
      logic [HANDLE_W-1:0] handle;
   } req_type;

   typedef struct packed {
      logic [HANDLE_W-1:0] result_handle;
      logic [POOL_W-1:0]   pool_number;
      logic [OFFSET_W-1:0] byte_offset;
      logic                status;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic exec;      // request accepted, carry out its action
      logic pop_load;  // link data returned, reload the free-list head
      logic mul_en;    // form the byte offset and present the result
      logic cfg_we;    // configuration write
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic need_pop;  // the request at the input would pop the free list
   } sts_type;

endpackage

// File: design/fixed_block_pool_allocator.sv
// An accepted request passes through the multiply state before its result is strobed;
// an allocate that pops the free list first waits in a pop state on the link store
// read port. The block takes no new request until it is idle again.
// The receiver cannot stall; each result is shown for one cycle only.
// Synchronous reset leaves one pool open with nothing used and the free list empty;
// the link store needs no clearing pass.
module fixed_block_pool_allocator (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  fbpa_pkg::req_type                req_payload,
   output logic                             rsp_valid,
   output fbpa_pkg::rsp_type                rsp_payload,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [fbpa_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [fbpa_pkg::CSR_DATA_W-1:0]  csr_data
);
   import fbpa_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // Sequencing of each transaction.
   fbpa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .csr_valid (csr_valid),
      .sts       (sts),
      .busy      (busy),
      .csr_ready (csr_ready),
      .cmd       (cmd)
   );

   // Allocator state, link store and offset arithmetic.
   fbpa_dpath u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .req_payload (req_payload),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

endmodule

// File: design/fbpa_ram.sv
module fbpa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/fbpa_ctrl.sv
module fbpa_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              csr_valid,
   input  fbpa_pkg::sts_type sts,
   output logic              busy,
   output logic              csr_ready,
   output fbpa_pkg::cmd_type cmd
);
   import fbpa_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_POP  = 3'b010,
      ST_MUL  = 3'b100
   } state_type;

   state_type state_ff;
   state_type state_in;

   // Next state: a pop passes through the pop state while it waits for the link store.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = sts.need_pop ? ST_POP : ST_MUL;
            end
         end
         ST_POP: begin
            state_in = ST_MUL;
         end
         ST_MUL: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Handshake and datapath commands.
   assign busy         = (state_ff != ST_IDLE);
   assign csr_ready    = (state_ff == ST_IDLE);
   assign cmd.exec     = start && (state_ff == ST_IDLE);
   assign cmd.pop_load = (state_ff == ST_POP);
   assign cmd.mul_en   = (state_ff == ST_MUL);
   assign cmd.cfg_we   = csr_valid && (state_ff == ST_IDLE);

endmodule

// File: design/fbpa_dpath.sv
module fbpa_dpath (
   input  logic                                clock,
   input  logic                                reset,
   input  fbpa_pkg::cmd_type                   cmd,
   output fbpa_pkg::sts_type                   sts,
   input  fbpa_pkg::req_type                   req_payload,
   input  logic [fbpa_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [fbpa_pkg::CSR_DATA_W-1:0]     csr_data,
   output logic                                rsp_valid,
   output fbpa_pkg::rsp_type                   rsp_payload
);
   import fbpa_pkg::*;

   // Configuration registers.
   logic [OBJ_W-1:0] object_size_ff;
   logic [SPP_W-1:0] slots_per_pool_ff;

   // Allocator state.
   logic [POOL_CNT_W-1:0] pools_ff, pools_in;
   logic [USED_W-1:0]     used_ff, used_in;
   logic [HANDLE_W-1:0]   head_ff, head_in;
   logic                  fvalid_ff, fvalid_in;

   // Result held between the action and the offset multiply.
   logic [HANDLE_W-1:0] hnd_ff, hnd_in;
   logic                status_ff, status_in;

   // Output registers.
   logic    rsp_valid_ff;
   rsp_type rsp_ff;

   // Link store port signals.
   logic                ram_we;
   logic                ram_re;
   logic [LINK_W-1:0]   ram_rdata;

   logic [USED_W-1:0]   n_eff;
   logic                slot_avail;
   logic                pool_room;
   logic [SLOT_W-1:0]   alloc_slot;
   logic [SLOT_W-1:0]   top_slot;
   logic [HANDLE_W-1:0] alloc_handle;
   logic [HANDLE_W-1:0] newpool_handle;
   logic [STRIDE_W-1:0] stride;
   logic [SLOT_W+STRIDE_W-1:0] product;

   // Effective slot count: zero acts as one, large values saturate.
   always_comb begin
      if (slots_per_pool_ff == '0) begin
         n_eff = USED_W'(1);
      end else if (slots_per_pool_ff > SPP_W'(MAX_POOL_SLOTS)) begin
         n_eff = USED_W'(MAX_POOL_SLOTS);
      end else begin
         n_eff = USED_W'(slots_per_pool_ff);
      end
   end

   assign slot_avail     = (used_ff < n_eff);
   assign pool_room      = (pools_ff < POOL_CNT_W'(MAX_POOLS));
   assign alloc_slot     = SLOT_W'(n_eff - used_ff - USED_W'(1));
   assign top_slot       = SLOT_W'(n_eff - USED_W'(1));
   assign alloc_handle   = HANDLE_W'({POOL_CNT_W'(pools_ff - POOL_CNT_W'(1)), alloc_slot});
   assign newpool_handle = HANDLE_W'({pools_ff, top_slot});

   assign sts.need_pop = (req_payload.operation == OP_ALLOC) && !slot_avail && fvalid_ff;

   // Action taken when a request is accepted, and the head reload after a pop.
   always_comb begin
      pools_in  = pools_ff;
      used_in   = used_ff;
      head_in   = head_ff;
      fvalid_in = fvalid_ff;
      hnd_in    = hnd_ff;
      status_in = status_ff;
      ram_we    = 1'b0;
      ram_re    = 1'b0;
      if (cmd.exec) begin
         status_in = STATUS_DONE;
         if (req_payload.operation == OP_RELEASE) begin
            ram_we    = 1'b1;
            head_in   = req_payload.handle;
            fvalid_in = 1'b1;
            hnd_in    = req_payload.handle;
         end else if (slot_avail) begin
            used_in = used_ff + USED_W'(1);
            hnd_in  = alloc_handle;
         end else if (fvalid_ff) begin
            ram_re = 1'b1;
            hnd_in = head_ff;
         end else if (pool_room) begin
            pools_in = pools_ff + POOL_CNT_W'(1);
            used_in  = USED_W'(1);
            hnd_in   = newpool_handle;
         end else begin
            hnd_in    = '0;
            status_in = STATUS_OOM;
         end
      end else if (cmd.pop_load) begin
         head_in   = ram_rdata[HANDLE_W-1:0];
         fvalid_in = ram_rdata[LINK_W-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pools_ff  <= POOL_CNT_W'(1);
         used_ff   <= '0;
         head_ff   <= '0;
         fvalid_ff <= 1'b0;
      end else begin
         pools_ff  <= pools_in;
         used_ff   <= used_in;
         head_ff   <= head_in;
         fvalid_ff <= fvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      hnd_ff    <= hnd_in;
      status_ff <= status_in;
   end

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         object_size_ff    <= OBJECT_SIZE_RESET;
         slots_per_pool_ff <= SLOTS_PER_POOL_RESET;
      end else if (cmd.cfg_we) begin
         case (csr_index)
            CSR_OBJECT_SIZE: begin
               object_size_ff <= csr_data;
            end
            CSR_SLOTS_PER_POOL: begin
               slots_per_pool_ff <= SPP_W'(csr_data);
            end
            default: begin
            end
         endcase
      end
   end

   // Link store: each entry holds the next handle and whether the list continues.
   fbpa_ram #(
      .WIDTH (LINK_W),
      .DEPTH (LINK_DEPTH)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (req_payload.handle),
      .wr_data ({fvalid_ff, head_ff}),
      .rd_en   (ram_re),
      .rd_addr (head_ff),
      .rd_data (ram_rdata)
   );

   // Byte offset of the slot: slot number times the stride.
   assign stride  = STRIDE_W'(object_size_ff) + STRIDE_W'(LINK_BYTES);
   assign product = (SLOT_W+STRIDE_W)'(hnd_ff[SLOT_W-1:0]) * (SLOT_W+STRIDE_W)'(stride);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.mul_en;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         rsp_ff.result_handle <= hnd_ff;
         rsp_ff.pool_number   <= POOL_W'(hnd_ff >> SLOT_W);
         rsp_ff.byte_offset   <= OFFSET_W'(product);
         rsp_ff.status        <= status_ff;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// File: design/fbpa_checker.sv
module fbpa_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input fbpa_pkg::req_type req_payload,
   input logic              rsp_valid,
   input fbpa_pkg::rsp_type rsp_payload
);
   import fbpa_pkg::*;

   logic accept;
   assign accept = start && !busy;

   // An accepted transaction keeps the block busy in the next cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("block not busy after an accepted transaction");

   // Results are never strobed back to back.
   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

   // A result appears only once the block is free again.
   a_idle_on_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobed while the block is busy");

   // A release answers with its own handle and done status.
   a_release_echo: assert property (@(posedge clock) disable iff (reset)
      (accept && req_payload.operation == OP_RELEASE) |-> ##2
         (rsp_valid && rsp_payload.result_handle == $past(req_payload.handle, 2) &&
          rsp_payload.status == STATUS_DONE))
      else $error("release transaction not echoed correctly");

   // An out-of-memory result carries zero fields.
   a_oom_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.status == STATUS_OOM) |->
         (rsp_payload.result_handle == '0 && rsp_payload.pool_number == '0 &&
          rsp_payload.byte_offset == '0))
      else $error("out-of-memory result has non-zero fields");

endmodule

bind fixed_block_pool_allocator fbpa_checker u_fbpa_checker (
   .clock       (clock),
   .reset       (reset),
   .start       (start),
   .busy        (busy),
   .req_payload (req_payload),
   .rsp_valid   (rsp_valid),
   .rsp_payload (rsp_payload)
);
